// File: rtl/stick_deadzone_axis_snap_defines.svh
// Assertion macros for the stick deadzone and axis snap block.
// Used by the top level only; no other dependencies.
`ifndef STICK_DEADZONE_AXIS_SNAP_DEFINES_SVH
`define STICK_DEADZONE_AXIS_SNAP_DEFINES_SVH
`ifndef SYNTHESIS
`define SDAS_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define SDAS_ASSERT_ZERO(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("output not zero in deadzone");
`else
`define SDAS_ASSERT_IMPL(label, clk, rst_n, prop)
`define SDAS_ASSERT_ZERO(label, clk, rst_n, prop)
`endif
`endif

// File: rtl/sdas_pkg.sv
// Shared types, constants and tables for the stick deadzone and axis snap block.
// No dependencies.
package sdas_pkg;
	localparam int TABLE_LEN = 24;
	localparam int CW = 34;
	localparam int ZW = 19;
	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_RIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;
	localparam logic [1:0] REG_INVERT = 2'd3;
	localparam logic [15:0] HALF_RIGHT = 16'd32768;

	function automatic logic [15:0] atan_units(input int i);
		logic [15:0] r;
		case (i)
			0: r = 16'd32768;
			1: r = 16'd19344;
			2: r = 16'd10221;
			3: r = 16'd5188;
			4: r = 16'd2604;
			5: r = 16'd1303;
			6: r = 16'd652;
			7: r = 16'd326;
			8: r = 16'd163;
			9: r = 16'd81;
			10: r = 16'd41;
			11: r = 16'd20;
			12: r = 16'd10;
			13: r = 16'd5;
			14: r = 16'd3;
			15: r = 16'd1;
			16: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Side information that rides alongside the CORDIC through the pipe.
	typedef struct packed {
		logic               side;
		logic               dead;
		logic               zero;
		logic [1:0]         quad;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} side_t;
endpackage

// File: rtl/stick_deadzone_axis_snap.sv
// Channel   | handshake            | payload
// in        | in_valid/in_ready    | stick_side, x_raw, y_raw
// out       | out_valid/out_ready  | x_out, y_out, in_deadzone, snapped
// cfg       | cfg_valid/cfg_ready  | cfg_index, cfg_data
// One request enters per cycle while out is not stalled. The CORDIC stages number
// CORDIC_STEPS limited to 24 but never below 16, padded so that the 16-stage root
// finishes with them; a result stage follows.
// Reset restores register defaults and empties the pipe. A stall on out freezes
// the whole pipe, so no request is lost or repeated.
// Depends on sdas_pkg, sdas_cordic, sdas_sqrt and the defines header.
`include "stick_deadzone_axis_snap_defines.svh"
module stick_deadzone_axis_snap #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               stick_side,
	input  logic signed [15:0] x_raw,
	input  logic signed [15:0] y_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] x_out,
	output logic signed [16:0] y_out,
	output logic               in_deadzone,
	output logic               snapped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	logic [14:0] left_q, right_q;
	logic [15:0] window_q;
	logic        invert_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 15'd7849;
			right_q <= 15'd8689;
			window_q <= 16'd10923;
			invert_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdas_pkg::REG_LEFT: left_q <= cfg_data[14:0];
				sdas_pkg::REG_RIGHT: right_q <= cfg_data[14:0];
				sdas_pkg::REG_WINDOW: window_q <= cfg_data;
				sdas_pkg::REG_INVERT: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Input decode: clamp, fold into first quadrant, squares and radius test.
	logic signed [15:0] x, y;
	logic [15:0] a, b;
	logic [1:0] q;
	logic [29:0] xx, yy, rr;
	logic [31:0] dsq;
	sdas_pkg::side_t sd;
	always_comb begin
		x = (x_raw == 16'sh8000) ? -16'sd32767 : x_raw;
		y = (y_raw == 16'sh8000) ? -16'sd32767 : y_raw;
		xx = 30'(32'(x) * 32'(x));
		yy = 30'(32'(y) * 32'(y));
		rr = stick_side ? right_q * right_q : left_q * left_q;
		if (x > 0 && y >= 0) begin
			q = 2'd0; a = x; b = y;
		end else if (x <= 0 && y > 0) begin
			q = 2'd1; a = y; b = -x;
		end else if (x < 0 && y <= 0) begin
			q = 2'd2; a = -x; b = -y;
		end else if (x >= 0 && y < 0) begin
			q = 2'd3; a = -y; b = x;
		end else begin
			q = 2'd0; a = '0; b = '0;
		end
		dsq = 32'(xx) + 32'(yy);
		sd.side = stick_side;
		sd.quad = q;
		sd.x = x;
		sd.y = y;
		sd.dead = dsq < 32'(rr);
		sd.zero = (x == 0) && (y == 0);
	end

	logic cv;
	logic [15:0] ang;
	sdas_pkg::side_t so;
	sdas_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid && in_ready),
		.a(a), .b(b), .in_side(sd), .out_valid(cv), .angle(ang), .out_side(so)
	);

	// The root of the squared distance is started 16 stages before the end.
	localparam int NS = (CORDIC_STEPS > sdas_pkg::TABLE_LEN) ? sdas_pkg::TABLE_LEN
		: CORDIC_STEPS;
	logic [31:0] dsq_d;
	logic [16:0] mag;
	if (NS > 16) begin : g_dly
		logic [31:0] d_s1 [NS-16];
		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[0] <= dsq;
				for (int i = 1; i < NS - 16; i++) d_s1[i] <= d_s1[i-1];
			end
		end
		assign dsq_d = d_s1[NS-17];
	end else begin : g_nodly
		assign dsq_d = dsq;
	end
	sdas_sqrt u_sqrt (.clk(clk), .en(en), .v(dsq_d), .root(mag));

	logic signed [16:0] xo, yo;
	logic sn;
	logic [1:0] qq;
	always_comb begin
		xo = {so.x[15], so.x};
		yo = {so.y[15], so.y};
		sn = 1'b0;
		qq = so.quad;
		if (!so.dead && ang < window_q) begin
			sn = 1'b1;
			if (ang >= sdas_pkg::HALF_RIGHT) qq = so.quad + 2'd1;
			case (qq)
				2'd0: begin xo = mag; yo = '0; end
				2'd1: begin xo = '0; yo = mag; end
				2'd2: begin xo = -mag; yo = '0; end
				default: begin xo = '0; yo = -mag; end
			endcase
		end
		if (so.side && invert_q) yo = -yo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= so.dead ? 17'sd0 : xo;
			y_out <= so.dead ? 17'sd0 : yo;
			in_deadzone <= so.dead;
			snapped <= so.dead ? 1'b0 : sn;
		end
	end

	`SDAS_ASSERT_ZERO(a_dead_zero, clk, arst_n, out_valid && in_deadzone |-> x_out == 0 && y_out == 0 && !snapped)
	`SDAS_ASSERT_IMPL(a_snap_axis, clk, arst_n, out_valid && snapped |-> x_out == 0 || y_out == 0)
	`SDAS_ASSERT_IMPL(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(x_out))
endmodule

// File: rtl/sdas_cordic.sv
// Pipelined CORDIC vectoring unit with side band, one micro-rotation per unpadded stage.
// Depends on sdas_pkg.
module sdas_cordic #(
	parameter int STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [15:0]              a,
	input  logic [15:0]              b,
	input  sdas_pkg::side_t          in_side,
	output logic                     out_valid,
	output logic [15:0]              angle,
	output sdas_pkg::side_t          out_side
);
	localparam int NS = (STEPS > sdas_pkg::TABLE_LEN) ? sdas_pkg::TABLE_LEN : STEPS;
	// At least 16 stages deep so the root unit beside it finishes on the same cycle.
	localparam int D = (NS < 16) ? 16 : NS;

	logic signed [sdas_pkg::CW-1:0] cx_s1 [D];
	logic signed [sdas_pkg::CW-1:0] cy_s1 [D];
	logic signed [sdas_pkg::ZW-1:0] z_s1 [D];
	sdas_pkg::side_t                sd_s1 [D];
	logic [D-1:0]                   v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= '0;
		end else if (en) begin
			v_s1 <= {v_s1[D-2:0], in_valid};
		end
	end

	// Stage 0 is the 45 degree rotation, later stages the table steps, then padding stages.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1[0] <= (sdas_pkg::CW'(a) + sdas_pkg::CW'(b)) <<< 14;
			cy_s1[0] <= (sdas_pkg::CW'(b) - sdas_pkg::CW'(a)) <<< 14;
			z_s1[0] <= sdas_pkg::ZW'(sdas_pkg::atan_units(0));
			sd_s1[0] <= in_side;
			for (int i = 1; i < D; i++) begin
				if (i >= NS) begin
					cx_s1[i] <= cx_s1[i-1];
					cy_s1[i] <= cy_s1[i-1];
					z_s1[i] <= z_s1[i-1];
				end else if (cy_s1[i-1] > 0) begin
					cx_s1[i] <= cx_s1[i-1] + (cy_s1[i-1] >>> i);
					cy_s1[i] <= cy_s1[i-1] - (cx_s1[i-1] >>> i);
					z_s1[i] <= z_s1[i-1] + sdas_pkg::ZW'(sdas_pkg::atan_units(i));
				end else begin
					cx_s1[i] <= cx_s1[i-1] - (cy_s1[i-1] >>> i);
					cy_s1[i] <= cy_s1[i-1] + (cx_s1[i-1] >>> i);
					z_s1[i] <= z_s1[i-1] - sdas_pkg::ZW'(sdas_pkg::atan_units(i));
				end
				sd_s1[i] <= sd_s1[i-1];
			end
		end
	end

	logic signed [sdas_pkg::ZW-1:0] zf;
	assign zf = z_s1[D-1];
	always_comb begin
		if (out_side.zero || zf < 0) begin
			angle = '0;
		end else if (zf > 65535) begin
			angle = 16'hFFFF;
		end else begin
			angle = zf[15:0];
		end
	end
	assign out_valid = v_s1[D-1];
	assign out_side = sd_s1[D-1];
endmodule

// File: rtl/sdas_sqrt.sv
// Pipelined rounded integer square root, one result bit per stage.
// No dependencies.
module sdas_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] v,
	output logic [16:0] root
);
	// 16 stages; each settles one bit of the floor root.
	logic [31:0] n_s1 [17];
	logic [15:0] r_s1 [17];

	always_comb begin
		n_s1[0] = v;
		r_s1[0] = '0;
	end

	for (genvar k = 0; k < 16; k++) begin : g_st
		localparam int B = 15 - k;
		logic [33:0] t;
		assign t = {2'b0, n_s1[k]} - (({18'd0, r_s1[k]} << (B + 1)) + (34'd1 << (2 * B)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!t[33]) begin
					n_s1[k+1] <= t[31:0];
					r_s1[k+1] <= r_s1[k] | (16'd1 << B);
				end else begin
					n_s1[k+1] <= n_s1[k];
					r_s1[k+1] <= r_s1[k];
				end
			end
		end
	end

	// Remainder v - r*r is n; round up when it exceeds r.
	assign root = (n_s1[16] > {16'd0, r_s1[16]}) ? {1'b0, r_s1[16]} + 17'd1
		: {1'b0, r_s1[16]};
endmodule
